### src/pws_pkg.sv
package pws_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int MEAN_W     = COORD_BITS + FRAC_BITS;
    localparam int IDX_W      = 16;
    localparam int HW_W       = 4;

    localparam logic [HW_W-1:0] HW_RESET = 4'd1;

    // Register index
    localparam logic REG_HALF_WINDOW = 1'b0;

    typedef struct packed {
        logic [COORD_BITS-1:0] cell_x;
        logic [COORD_BITS-1:0] cell_y;
        logic                  path_end;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_x;
        logic [MEAN_W-1:0] mean_y;
        logic [IDX_W-1:0]  point_index;
        logic              final_point;
    } t_out_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_point;

    // Sequencer to window walker
    typedef struct packed {
        logic wr_en;
        logic start;
    } t_ring_cmd;

endpackage

### src/pws_div.sv
module pws_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot,
    output logic             o_done
);
    import pws_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;

    // restoring step: one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DVS_W]) begin
                r_rem  <= w_diff[DVS_W-1:0];
                r_quot <= {r_quot[DVD_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[DVS_W-1:0];
                r_quot <= {r_quot[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

### src/pws_ring.sv
module pws_ring #(
    parameter int RING_DEPTH = 32,
    parameter int CNT_W      = 5,
    parameter int SUM_W      = 21
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pws_pkg::t_ring_cmd              i_cmd,
    input  logic [$clog2(RING_DEPTH)-1:0]   i_wr_addr,
    input  pws_pkg::t_point                 i_wr_point,
    input  logic [$clog2(RING_DEPTH)-1:0]   i_newest,
    input  logic [CNT_W-1:0]                i_count,
    output logic                            o_done,
    output logic [SUM_W-1:0]                o_sum_x,
    output logic [SUM_W-1:0]                o_sum_y
);
    import pws_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    t_point           mem [RING_DEPTH];
    t_point           r_rd_data;
    logic [AW-1:0]    r_addr;
    logic [CNT_W-1:0] r_iss_cnt;
    logic             r_rd_vld;
    logic             r_done;
    logic [SUM_W-1:0] r_sum_x;
    logic [SUM_W-1:0] r_sum_y;

    // point memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= i_wr_point;
        end
        r_rd_data <= mem[r_addr];
    end

    // walk backward from the newest slot, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_cnt <= '0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_rd_vld <= (r_iss_cnt != '0);
            r_done   <= r_rd_vld && (r_iss_cnt == '0);
            if (i_cmd.start) begin
                r_iss_cnt <= i_count;
            end else if (r_iss_cnt != '0) begin
                r_iss_cnt <= r_iss_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr  <= i_newest;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            if (r_iss_cnt != '0) begin
                r_addr <= (r_addr == '0) ? AW'(RING_DEPTH - 1) : r_addr - AW'(1);
            end
            if (r_rd_vld) begin
                r_sum_x <= r_sum_x + SUM_W'(r_rd_data.x);
                r_sum_y <= r_sum_y + SUM_W'(r_rd_data.y);
            end
        end
    end

    assign o_done  = r_done;
    assign o_sum_x = r_sum_x;
    assign o_sum_y = r_sum_y;

endmodule

### src/path_point_window_smoother.sv
// Channel   Handshake                  Payload             Moves
// input     i_in_valid / o_in_ready    i_in_data           one path point per transfer
// output    o_out_valid / i_out_ready  o_out_data          one smoothed point per transfer
// config    psel penable pwrite pready paddr pwdata prdata half_window register at 0x0
//
// Each mean takes a ring walk of COUNT points (one memory read a cycle) and
// two passes of the shared radix-2 divider (29 quotient bits each; x, then
// y), plus start and load. A point that emits nothing leaves the sequencer
// idle; the final point of a path takes one mean time per pending point.
// Reset is synchronous, active low; no clearing pass is run.
// A stalled output holds one finished result in the output register; the
// sequencer waits only when a second result is ready to load.
module path_point_window_smoother #(
    parameter int MAX_HALF_WINDOW = 15,
    parameter int RING_DEPTH      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // point input
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pws_pkg::t_in_item   i_in_data,
    // smoothed output
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pws_pkg::t_out_item  o_out_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pws_pkg::*;

    // effective half-window limit
    localparam int HLIM  = (MAX_HALF_WINDOW < (RING_DEPTH - 1) / 2) ?
                           MAX_HALF_WINDOW : (RING_DEPTH - 1) / 2;
    localparam int H_W   = $clog2(HLIM + 1);
    localparam int ML_W  = $clog2(HLIM + 2);
    localparam int CNT_W = $clog2(2 * HLIM + 2);
    localparam int AW    = $clog2(RING_DEPTH);
    localparam int SUM_W = COORD_BITS + CNT_W;
    localparam int DVD_W = SUM_W + FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SUM,
        S_DIV_X,
        S_DIV_Y,
        S_LOAD
    } t_state;

    t_state            r_state;
    logic [HW_W-1:0]   r_half_window;
    logic [H_W-1:0]    r_active_h;
    logic [AW-1:0]     r_newest;
    logic [IDX_W-1:0]  r_points_seen;
    logic [IDX_W-1:0]  r_next_out;
    logic [H_W-1:0]    r_taken;      // saturating, zero marks path start
    logic [H_W-1:0]    r_emitted;    // saturating
    logic [ML_W-1:0]   r_means_left;
    logic [H_W-1:0]    r_right;
    logic              r_flush;
    logic [CNT_W-1:0]  r_count;
    logic [MEAN_W-1:0] r_mean_x;
    logic [MEAN_W-1:0] r_mean_y;
    logic              r_out_vld;
    t_out_item         r_out_data;

    logic              w_in_xfer;
    logic              w_out_xfer;
    logic              w_cfg_wr;
    logic              w_path_start;
    logic [H_W-1:0]    w_h_use;
    logic [AW-1:0]     w_slot;
    logic [IDX_W-1:0]  w_seen_new;
    logic [IDX_W-1:0]  w_pend_raw;
    logic [IDX_W-1:0]  w_pend_cap;
    logic [ML_W-1:0]   w_pending;
    logic [H_W-1:0]    w_left;
    logic [CNT_W-1:0]  w_count;
    logic              w_load;
    logic              w_last_mean;

    t_ring_cmd         w_ring_cmd;
    t_point            w_wr_point;
    logic              w_ring_done;
    logic [SUM_W-1:0]  w_sum_x;
    logic [SUM_W-1:0]  w_sum_y;

    logic              w_div_start;
    logic [DVD_W-1:0]  w_dividend;
    logic [DVD_W-1:0]  w_quot;
    logic              w_div_done;

    function automatic logic [H_W-1:0] f_limit(input logic [HW_W-1:0] hw);
        if (int'(hw) > HLIM) begin
            return H_W'(HLIM);
        end else begin
            return H_W'(hw);
        end
    endfunction

    // register port: one register, word index in paddr[2]
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HALF_WINDOW);
    assign prdata   = (paddr[2] == REG_HALF_WINDOW) ? {28'd0, r_half_window} : 32'd0;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = r_out_vld && i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // window is latched on the first point of a path
    assign w_path_start = (r_taken == '0);
    assign w_h_use      = w_path_start ? f_limit(r_half_window) : r_active_h;
    assign w_slot       = w_path_start ? '0 :
                          (r_newest == AW'(RING_DEPTH - 1)) ? '0 : r_newest + AW'(1);
    assign w_seen_new   = r_points_seen + IDX_W'(1);

    // points still owed at the end of a path, at most h+1
    assign w_pend_raw = w_seen_new - r_next_out;
    assign w_pend_cap = IDX_W'(w_h_use) + IDX_W'(1);
    assign w_pending  = (w_pend_raw > w_pend_cap) ? ML_W'(w_pend_cap) : ML_W'(w_pend_raw);

    // the window always ends at the newest point: count = left + right + 1
    assign w_left  = (r_emitted < r_active_h) ? r_emitted : r_active_h;
    assign w_count = CNT_W'(w_left) + CNT_W'(r_right) + CNT_W'(1);

    assign w_load      = (r_state == S_LOAD) && (!r_out_vld || i_out_ready);
    assign w_last_mean = (r_means_left == ML_W'(1));

    assign w_ring_cmd.wr_en = w_in_xfer;
    assign w_ring_cmd.start = (r_state == S_START);
    assign w_wr_point.x     = i_in_data.cell_x;
    assign w_wr_point.y     = i_in_data.cell_y;

    assign w_div_start = ((r_state == S_SUM) && w_ring_done) ||
                         ((r_state == S_DIV_X) && w_div_done);
    assign w_dividend  = (r_state == S_SUM) ? {w_sum_x, {FRAC_BITS{1'b0}}}
                                            : {w_sum_y, {FRAC_BITS{1'b0}}};

    pws_ring #(
        .RING_DEPTH (RING_DEPTH),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_ring_cmd),
        .i_wr_addr  (w_slot),
        .i_wr_point (w_wr_point),
        .i_newest   (r_newest),
        .i_count    (w_count),
        .o_done     (w_ring_done),
        .o_sum_x    (w_sum_x),
        .o_sum_y    (w_sum_y)
    );

    pws_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // sequencer: state, path counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_half_window <= HW_RESET;
            r_active_h    <= f_limit(HW_RESET);
            r_newest      <= '0;
            r_points_seen <= '0;
            r_next_out    <= '0;
            r_taken       <= '0;
            r_emitted     <= '0;
            r_means_left  <= '0;
            r_right       <= '0;
            r_flush       <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_half_window <= pwdata[HW_W-1:0];
            end
            if (w_out_xfer && !w_load) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_active_h    <= w_h_use;
                        r_newest      <= w_slot;
                        r_points_seen <= w_seen_new;
                        if (i_in_data.path_end) begin
                            // flush every pending point, oldest first
                            r_means_left <= w_pending;
                            r_right      <= H_W'(w_pending - ML_W'(1));
                            r_flush      <= 1'b1;
                            r_state      <= S_START;
                        end else begin
                            if (r_taken != '1) begin
                                r_taken <= r_taken + H_W'(1);
                            end
                            if (r_taken >= w_h_use) begin
                                r_means_left <= ML_W'(1);
                                r_right      <= w_h_use;
                                r_flush      <= 1'b0;
                                r_state      <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    r_count <= w_count;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (w_ring_done) begin
                        r_state <= S_DIV_X;
                    end
                end
                S_DIV_X: begin
                    if (w_div_done) begin
                        r_mean_x <= w_quot[MEAN_W-1:0];
                        r_state  <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (w_div_done) begin
                        r_mean_y <= w_quot[MEAN_W-1:0];
                        r_state  <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_out_vld                <= 1'b1;
                        r_out_data.mean_x        <= r_mean_x;
                        r_out_data.mean_y        <= r_mean_y;
                        r_out_data.point_index   <= r_next_out;
                        r_out_data.final_point   <= r_flush && w_last_mean;
                        r_means_left <= r_means_left - ML_W'(1);
                        r_right      <= r_right - H_W'(r_flush);
                        if (w_last_mean && r_flush) begin
                            // path closed
                            r_state       <= S_IDLE;
                            r_points_seen <= '0;
                            r_next_out    <= '0;
                            r_taken       <= '0;
                            r_emitted     <= '0;
                        end else begin
                            r_next_out <= r_next_out + IDX_W'(1);
                            if (r_emitted != '1) begin
                                r_emitted <= r_emitted + H_W'(1);
                            end
                            if (w_last_mean) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_START;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ring_done_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_done |-> (r_state == S_SUM))
        else $error("window sum finished outside the sum phase");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_X || r_state == S_DIV_Y))
        else $error("divider finished outside a divide phase");

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_means_left != '0))
        else $error("sequencer busy with no mean pending");

    a_path_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_flush && w_last_mean) |=>
            (r_taken == '0 && r_next_out == '0 && r_emitted == '0))
        else $error("path counters not cleared after final point");
`endif

endmodule

### tb/sv/path_point_window_smoother_test.sv
// Testbench for the path point window smoother.
// Path points go in over the valid/ready input channel; each accepted transfer
// is run through a local model of the centered moving average, which queues
// the smoothed points it expects. A monitor on the output channel checks each
// transfer field by field against the oldest queued point.
module path_point_window_smoother_test;
    import pws_pkg::*;

    localparam int RING_N         = 32;   // block default RING_DEPTH
    localparam int HW_MAX         = 15;   // block default MAX_HALF_WINDOW
    localparam int SAT_LIMIT      = 255;  // saturation limit of the model's per-path counters
    localparam int REG_UNUSED     = 1;    // register index with nothing behind it
    localparam int SETTLE_CYCLES  = 200;  // above one mean time at the widest window
    localparam int TAIL_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 4000000;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_WALK,
        STYLE_HIGH,
        STYLE_LOW
    } t_coord_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // idling knobs, in percent per cycle
    int idle_pct  = 0;
    int stall_pct = 0;
    int bad_results = 0;

    // smoothed points still owed by the block, oldest first
    t_out_item expected_means[$];

    // model state
    t_point      ring_pts[RING_N];
    int unsigned newest_slot;
    logic [15:0] pts_taken;
    logic [15:0] out_index;
    int unsigned taken_cnt;
    int unsigned emitted_cnt;
    int unsigned path_hw;     // window latched at the first point of a path
    logic [3:0]  cfg_hw;      // register copy

    path_point_window_smoother uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic note_failure(input string msg);
        if (bad_results < MAX_REPORTS) begin
            $display("%s", msg);
        end
        bad_results++;
    endtask

    // Queue the mean of the point 'back' places behind the newest one.
    // Left side shrinks while the path start is still within the window.
    task automatic push_window_mean(input int unsigned back, input int unsigned right,
                                    input bit last_one);
        int unsigned left;
        int unsigned count;
        int unsigned slot;
        logic [39:0] sx;
        logic [39:0] sy;
        t_out_item   m;
        left = (emitted_cnt < path_hw) ? emitted_cnt : path_hw;
        count = left + right + 1;
        sx = '0;
        sy = '0;
        for (int unsigned i = 0; i < count; i++) begin
            slot = (newest_slot + RING_N - ((back - right + i) % RING_N)) % RING_N;
            sx += ring_pts[slot].x;
            sy += ring_pts[slot].y;
        end
        m.mean_x      = MEAN_W'((sx << FRAC_BITS) / count);
        m.mean_y      = MEAN_W'((sy << FRAC_BITS) / count);
        m.point_index = out_index;
        m.final_point = last_one;
        expected_means.insert(expected_means.size(), m);
        out_index++;
        if (emitted_cnt < SAT_LIMIT) emitted_cnt++;
    endtask

    task automatic predict_smoothing(input t_in_item it);
        logic [15:0] pending;
        int unsigned n_flush;
        if (taken_cnt == 0) begin
            // new path: latch the window, clamp to what the ring can hold
            path_hw = cfg_hw;
            if (path_hw > HW_MAX) path_hw = HW_MAX;
            if (path_hw > (RING_N - 1) / 2) path_hw = (RING_N - 1) / 2;
            newest_slot = RING_N - 1;
        end
        newest_slot = (newest_slot + 1) % RING_N;
        ring_pts[newest_slot].x = it.cell_x;
        ring_pts[newest_slot].y = it.cell_y;
        pts_taken++;
        if (!it.path_end) begin
            if (taken_cnt >= path_hw) push_window_mean(path_hw, path_hw, 1'b0);
            if (taken_cnt < SAT_LIMIT) taken_cnt++;
        end else begin
            // flush: every point still pending, right side shrinking to zero
            pending = pts_taken - out_index;
            n_flush = pending;
            if (n_flush > path_hw + 1) n_flush = path_hw + 1;
            for (int unsigned j = 0; j < n_flush; j++) begin
                push_window_mean(n_flush - 1 - j, n_flush - 1 - j, (j + 1 == n_flush));
            end
            pts_taken   = '0;
            out_index   = '0;
            taken_cnt   = 0;
            emitted_cnt = 0;
        end
    endtask

    // output monitor
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_means.size() == 0) begin
                note_failure($sformatf("unexpected transfer: x=%h y=%h idx=%0d fin=%b",
                    o_out_data.mean_x, o_out_data.mean_y, o_out_data.point_index,
                    o_out_data.final_point));
            end else begin
                want = expected_means.pop_front();
                if (o_out_data.mean_x !== want.mean_x || o_out_data.mean_y !== want.mean_y
                        || o_out_data.point_index !== want.point_index
                        || o_out_data.final_point !== want.final_point) begin
                    note_failure($sformatf(
                        "mismatch: want x=%h y=%h idx=%0d fin=%b, got x=%h y=%h idx=%0d fin=%b",
                        want.mean_x, want.mean_y, want.point_index, want.final_point,
                        o_out_data.mean_x, o_out_data.mean_y, o_out_data.point_index,
                        o_out_data.final_point));
                end
            end
        end
    end

    // One input transfer. Valid stays up across back-to-back points; a gap
    // drops it for a random number of cycles.
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit last_pt);
        t_in_item it;
        it.cell_x   = x;
        it.cell_y   = y;
        it.path_end = last_pt;
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_smoothing(it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Wait until every owed point has come out, then let the block settle.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input int unsigned index, input logic [31:0] value);
        drain_block();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (index == int'(REG_HALF_WINDOW)) cfg_hw = value[HW_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_window_readback();
        drain_block();
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= 3'(int'(REG_HALF_WINDOW) * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[HW_W-1:0] !== cfg_hw) begin
            note_failure($sformatf("readback: want %0d got %0d", cfg_hw, prdata[HW_W-1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] next_coord(input t_coord_style style,
                                               input logic [15:0] prev);
        case (style)
            STYLE_RANDOM: return 16'($urandom);
            STYLE_WALK:   return prev + 16'($urandom_range(2)) - 16'd1;
            STYLE_HIGH:   return 16'hFFFF - 16'($urandom_range(15));
            default:      return 16'($urandom_range(15));
        endcase
    endfunction

    // ---- directed tests ----

    // reset window of one; extremes of both coordinates
    task automatic test_default_window();
        check_window_readback();
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'h0001, 16'h0002, 1'b1);
    endtask

    // a single-point path comes out unchanged, at both window extremes
    task automatic test_one_point_path();
        apb_write(int'(REG_HALF_WINDOW), 32'd0);
        check_window_readback();
        send_point(16'hFFFF, 16'h0000, 1'b1);
        apb_write(int'(REG_HALF_WINDOW), 32'd15);
        check_window_readback();
        send_point(16'h0000, 16'hFFFF, 1'b1);
    endtask

    // path shorter than the window: nothing until the end, then all of it
    task automatic test_short_path();
        for (int i = 0; i < 5; i++) send_point(16'hFFFF, 16'hFFFF, (i == 4));
    endtask

    // a write in mid path only takes effect on the next path
    task automatic test_window_change_mid_path();
        apb_write(int'(REG_HALF_WINDOW), 32'd2);
        send_point(16'd10, 16'd20, 1'b0);
        send_point(16'd30, 16'd40, 1'b0);
        send_point(16'd50, 16'd60, 1'b0);
        apb_write(int'(REG_HALF_WINDOW), 32'd0);
        send_point(16'd70, 16'd80, 1'b0);
        send_point(16'd90, 16'd100, 1'b1);
        send_point(16'd5, 16'd6, 1'b0);
        send_point(16'd7, 16'd8, 1'b1);
    endtask

    // a write to an unused index must leave the window alone
    task automatic test_unused_register();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        check_window_readback();
        send_point(16'd1, 16'd1, 1'b0);
        send_point(16'd2, 16'd2, 1'b0);
        send_point(16'd3, 16'd3, 1'b1);
    endtask

    // ---- random tests ----

    // one path longer than the saturating counters, as a grid walk
    task automatic test_long_path();
        logic [15:0] x;
        logic [15:0] y;
        idle_pct  = 0;
        stall_pct = 0;
        apb_write(int'(REG_HALF_WINDOW), 32'd3);
        x = 16'($urandom);
        y = 16'($urandom);
        for (int i = 0; i < 270; i++) begin
            send_point(x, y, (i == 269));
            x = next_coord(STYLE_WALK, x);
            y = next_coord(STYLE_WALK, y);
        end
    endtask

    // Mostly well-formed paths with random content; some noisy paths end at
    // random points. The window is sometimes rewritten between paths.
    task automatic test_random_traffic(input int idle_in, input int stall_out,
                                       input int n_items, input logic [3:0] start_hw);
        int budget;
        int len;
        bit noisy;
        bit last_pt;
        t_coord_style style;
        logic [15:0] x;
        logic [15:0] y;
        idle_pct  = idle_in;
        stall_pct = stall_out;
        apb_write(int'(REG_HALF_WINDOW), {28'd0, start_hw});
        budget = n_items;
        while (budget > 0) begin
            if ($urandom_range(4) == 0) len = $urandom_range(cfg_hw + 1, 1);
            else len = $urandom_range(2 * cfg_hw + 8, 1);
            noisy = ($urandom_range(99) < 15);
            style = t_coord_style'($urandom_range(3));
            x = 16'($urandom);
            y = 16'($urandom);
            last_pt = 1'b0;
            for (int k = 0; k < len && !last_pt; k++) begin
                x = next_coord(style, x);
                y = next_coord(style, y);
                last_pt = (k == len - 1) || (budget == 1) || (noisy && $urandom_range(3) == 0);
                send_point(x, y, last_pt);
                budget--;
            end
            if (budget > 0 && $urandom_range(3) == 0) begin
                case ($urandom_range(2))
                    0:       apb_write(int'(REG_HALF_WINDOW), 32'd0);
                    1:       apb_write(int'(REG_HALF_WINDOW), 32'd15);
                    default: apb_write(int'(REG_HALF_WINDOW), 32'($urandom_range(15)));
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        for (int i = 0; i < RING_N; i++) ring_pts[i] = '0;
        newest_slot = 0;
        pts_taken   = '0;
        out_index   = '0;
        taken_cnt   = 0;
        emitted_cnt = 0;
        cfg_hw      = HW_RESET;
        path_hw     = HW_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_one_point_path();
        test_short_path();
        test_window_change_mid_path();
        test_unused_register();
        test_long_path();
        test_random_traffic(0, 0, 35, 4'd0);
        test_random_traffic(66, 0, 35, 4'd15);
        test_random_traffic(0, 66, 35, 4'd7);
        test_random_traffic(19, 19, 35, 4'($urandom_range(15)));

        // everything owed must arrive, and nothing extra after it
        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
src/pws_pkg.sv
src/pws_div.sv
src/pws_ring.sv
src/path_point_window_smoother.sv
tb/sv/path_point_window_smoother_test.sv
